// ===== design/lfps_pkg.sv =====
// Shared types, constants and lookup tables of the LED fade program sequencer.
`timescale 1ns / 1ps

package lfps_pkg;

  localparam int TABLE_STEPS = 101;
  localparam int DUTY_FULL   = 10000;

  localparam int DUTY_W  = 14;
  localparam int LEVEL_W = 7;
  localparam int SEG_W   = 3;
  localparam int TICK_W  = 16;
  localparam int PROG_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_PROGS = 4;
  localparam int MAX_SEGS  = 6;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = LEVEL_W'(TABLE_STEPS - 1);
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd100;
  localparam logic [DUTY_W-1:0]  DUTY_LIMIT  = DUTY_W'(DUTY_FULL);

  // Program codes carried by the program request.
  localparam logic [PROG_W-1:0] PROG_STEADY = 2'd0;
  localparam logic [PROG_W-1:0] PROG_SLOW   = 2'd1;
  localparam logic [PROG_W-1:0] PROG_NORMAL = 2'd2;
  localparam logic [PROG_W-1:0] PROG_BLINK  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SLOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUICK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEADY = 3'd4;

  // Which tick register times a segment.
  typedef enum logic [2:0] {
    KIND_SLOW,
    KIND_NORMAL,
    KIND_QUICK,
    KIND_HOLD,
    KIND_STEADY
  } seg_kind_e;

  typedef struct packed {
    logic [TICK_W-1:0] slow_ticks;
    logic [TICK_W-1:0] normal_ticks;
    logic [TICK_W-1:0] quick_ticks;
    logic [TICK_W-1:0] hold_ticks;
    logic [TICK_W-1:0] steady_ticks;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic [LEVEL_W-1:0] level;
    logic [SEG_W-1:0]   segment;
    logic               restarted;
  } result_t;

  localparam logic [SEG_W-1:0] SEG_COUNT [NUM_PROGS] = '{3'd1, 3'd2, 3'd2, 3'd6};

  localparam logic [LEVEL_W-1:0] SEG_FROM [NUM_PROGS][MAX_SEGS] = '{
    '{7'd100, 7'd0,   7'd0,   7'd0,  7'd0,   7'd0},
    '{7'd0,   7'd100, 7'd0,   7'd0,  7'd0,   7'd0},
    '{7'd0,   7'd100, 7'd0,   7'd0,  7'd0,   7'd0},
    '{7'd20,  7'd100, 7'd100, 7'd50, 7'd100, 7'd100}
  };

  localparam logic [LEVEL_W-1:0] SEG_TO [NUM_PROGS][MAX_SEGS] = '{
    '{7'd100, 7'd0,   7'd0,  7'd0,   7'd0,   7'd0},
    '{7'd100, 7'd0,   7'd0,  7'd0,   7'd0,   7'd0},
    '{7'd100, 7'd0,   7'd0,  7'd0,   7'd0,   7'd0},
    '{7'd100, 7'd100, 7'd50, 7'd100, 7'd100, 7'd20}
  };

  localparam seg_kind_e SEG_KIND [NUM_PROGS][MAX_SEGS] = '{
    '{KIND_STEADY, KIND_HOLD,   KIND_HOLD,  KIND_HOLD,  KIND_HOLD, KIND_HOLD},
    '{KIND_SLOW,   KIND_SLOW,   KIND_HOLD,  KIND_HOLD,  KIND_HOLD, KIND_HOLD},
    '{KIND_NORMAL, KIND_NORMAL, KIND_HOLD,  KIND_HOLD,  KIND_HOLD, KIND_HOLD},
    '{KIND_NORMAL, KIND_HOLD,   KIND_QUICK, KIND_QUICK, KIND_HOLD, KIND_NORMAL}
  };

  // Exponential brightness curve in hundredths of a percent.
  localparam logic [DUTY_W-1:0] BRIGHT_TABLE [TABLE_STEPS] = '{
    14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd1, 14'd1,
    14'd1, 14'd1, 14'd2, 14'd2, 14'd2, 14'd2, 14'd3, 14'd3, 14'd4, 14'd4,
    14'd5, 14'd5, 14'd6, 14'd7, 14'd8, 14'd9, 14'd9, 14'd11, 14'd12, 14'd13,
    14'd14, 14'd16, 14'd18, 14'd19, 14'd21, 14'd24, 14'd26, 14'd29, 14'd32, 14'd35,
    14'd38, 14'd42, 14'd46, 14'd51, 14'd56, 14'd62, 14'd68, 14'd74, 14'd82, 14'd90,
    14'd99, 14'd108, 14'd119, 14'd130, 14'd143, 14'd157, 14'd172, 14'd189, 14'd207,
    14'd228, 14'd250, 14'd274, 14'd300, 14'd330, 14'd362, 14'd397, 14'd435, 14'd477,
    14'd523, 14'd574, 14'd629, 14'd690, 14'd757, 14'd830, 14'd911, 14'd999,
    14'd1095, 14'd1201, 14'd1317, 14'd1444, 14'd1583, 14'd1736, 14'd1904, 14'd2088,
    14'd2289, 14'd2510, 14'd2753, 14'd3018, 14'd3310, 14'd3629, 14'd3980, 14'd4364,
    14'd4785, 14'd5247, 14'd5753, 14'd6308, 14'd6917, 14'd7584, 14'd8316, 14'd9119,
    14'd10000
  };

  // Duty for a level, with the level and the duty both kept inside their bounds.
  function automatic logic [DUTY_W-1:0] lfps_duty(input logic [LEVEL_W-1:0] lvl);
    logic [LEVEL_W-1:0] idx;
    logic [DUTY_W-1:0]  d;
    idx = (lvl > LEVEL_MAX) ? LEVEL_MAX : lvl;
    d   = BRIGHT_TABLE[idx];
    return (d > DUTY_LIMIT) ? DUTY_LIMIT : d;
  endfunction

endpackage

// ===== design/led_fade_program_sequencer.sv =====
// Top level of the LED fade program sequencer: input register, step logic, result register.
// An accepted word waits in the input register; its result is registered as the word moves on.
// Throughput: one word per cycle unless the result stalls; the tick step is a single pass through lfps_core.
// A stalled result holds still; the input stalls only once the input register is full too.
// Reset (rst_ni low, asynchronous): both stages empty, steady-on program, level 100,
// tick counter zero and the tick registers at their default values.
`timescale 1ns / 1ps

module led_fade_program_sequencer import lfps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Tick input channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PROG_W-1:0]    program_req_i,
  // Result channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DUTY_W-1:0]    duty_o,
  output logic [LEVEL_W-1:0]   level_o,
  output logic [SEG_W-1:0]     segment_o,
  output logic                 restarted_o,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TICK_W-1:0]    cfg_wdata_i
);

  logic              in_valid_q;
  logic [PROG_W-1:0] in_req_q;
  logic              out_valid_q;
  result_t           out_res_q;
  result_t           core_res;
  cfg_t              cfg;
  logic              advance;
  logic              step;

  // The result register can take a new word when it is empty or its word leaves now.
  assign advance    = !out_valid_q || !out_stall_i;
  // The input register only blocks when it holds a word that cannot move on.
  assign in_stall_o = in_valid_q && !advance;
  // The program state steps exactly once per tick word, as it moves to the result.
  assign step       = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers load only with a word, so a stalled result holds still.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_req_q <= program_req_i;
    end
    if (step) begin
      out_res_q <= core_res;
    end
  end

  lfps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lfps_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .req_i    (in_req_q),
    .cfg_i    (cfg),
    .result_o (core_res)
  );

  assign out_valid_o = out_valid_q;
  assign duty_o      = out_res_q.duty;
  assign level_o     = out_res_q.level;
  assign segment_o   = out_res_q.segment;
  assign restarted_o = out_res_q.restarted;

endmodule

// ===== design/lfps_cfg_regs.sv =====
// Tick configuration registers of the LED fade program sequencer.
`timescale 1ns / 1ps

module lfps_cfg_regs import lfps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TICK_W-1:0]    cfg_wdata_i,
  output cfg_t                 cfg_o
);

  cfg_t              cfg_q;
  logic [TICK_W-1:0] wdata;

  // A written zero counts as one tick, so it is stored as one.
  assign wdata = (cfg_wdata_i == '0) ? TICK_W'(1) : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slow_ticks   <= 16'd20;
      cfg_q.normal_ticks <= 16'd10;
      cfg_q.quick_ticks  <= 16'd2;
      cfg_q.hold_ticks   <= 16'd200;
      cfg_q.steady_ticks <= 16'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SLOW:   cfg_q.slow_ticks   <= wdata;
        REG_NORMAL: cfg_q.normal_ticks <= wdata;
        REG_QUICK:  cfg_q.quick_ticks  <= wdata;
        REG_HOLD:   cfg_q.hold_ticks   <= wdata;
        REG_STEADY: cfg_q.steady_ticks <= wdata;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/lfps_core.sv =====
// Program state and the combinational step logic of the LED fade program sequencer.
`timescale 1ns / 1ps

module lfps_core import lfps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [PROG_W-1:0] req_i,
  input  cfg_t              cfg_i,
  output result_t           result_o
);

  logic [PROG_W-1:0]  prog_q, prog_d;
  logic [SEG_W-1:0]   seg_q, seg_d;
  logic [LEVEL_W-1:0] lvl_q, lvl_d;
  logic [TICK_W-1:0]  ticks_q, ticks_d;

  logic               changed, load;
  logic [SEG_W-1:0]   seg_cur, seg_nxt;
  logic [LEVEL_W-1:0] lvl_cur, target;
  logic [TICK_W-1:0]  ticks_cur, ticks_dec;

  function automatic logic [TICK_W-1:0] seg_len(input seg_kind_e kind, input cfg_t c);
    logic [TICK_W-1:0] v;
    unique case (kind)
      KIND_SLOW:   v = c.slow_ticks;
      KIND_NORMAL: v = c.normal_ticks;
      KIND_QUICK:  v = c.quick_ticks;
      KIND_HOLD:   v = c.hold_ticks;
      KIND_STEADY: v = c.steady_ticks;
      default:     v = c.hold_ticks;
    endcase
    return v;
  endfunction

  always_comb begin
    changed = (req_i != prog_q);
    load    = changed || (ticks_q == '0);

    // After a change or at start-up the segment list is entered at its head.
    seg_cur   = load ? '0 : seg_q;
    lvl_cur   = load ? SEG_FROM[req_i][0] : lvl_q;
    ticks_cur = load ? seg_len(SEG_KIND[req_i][0], cfg_i) : ticks_q;
    ticks_dec = ticks_cur - TICK_W'(1);

    target  = SEG_TO[req_i][seg_cur];
    seg_nxt = seg_cur + SEG_W'(1);
    if (seg_nxt >= SEG_COUNT[req_i]) begin
      seg_nxt = '0;
    end

    prog_d  = req_i;
    seg_d   = seg_cur;
    lvl_d   = lvl_cur;
    ticks_d = ticks_dec;
    if (ticks_dec == '0) begin
      if (lvl_cur != target) begin
        lvl_d   = (lvl_cur < target) ? lvl_cur + LEVEL_W'(1) : lvl_cur - LEVEL_W'(1);
        ticks_d = seg_len(SEG_KIND[req_i][seg_cur], cfg_i);
      end else begin
        seg_d   = seg_nxt;
        lvl_d   = SEG_FROM[req_i][seg_nxt];
        ticks_d = seg_len(SEG_KIND[req_i][seg_nxt], cfg_i);
      end
    end

    result_o.duty      = lfps_duty(lvl_cur);
    result_o.level     = lvl_cur;
    result_o.segment   = seg_cur;
    result_o.restarted = changed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q  <= PROG_STEADY;
      seg_q   <= '0;
      lvl_q   <= LEVEL_RESET;
      ticks_q <= '0;
    end else if (step_i) begin
      prog_q  <= prog_d;
      seg_q   <= seg_d;
      lvl_q   <= lvl_d;
      ticks_q <= ticks_d;
    end
  end

endmodule

// ===== design/lfps_checker.sv =====
// Port-level assertions for the LED fade program sequencer, bound to the top level.
`timescale 1ns / 1ps

module lfps_checker import lfps_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [DUTY_W-1:0]    duty_o,
  input logic [LEVEL_W-1:0]   level_o,
  input logic [SEG_W-1:0]     segment_o,
  input logic                 restarted_o
);

  // A stalled result word keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(duty_o) && $stable(level_o)
      && $stable(segment_o) && $stable(restarted_o))
    else $error("stalled result word changed");

  // The duty always matches the brightness curve at the reported level.
  a_duty_curve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_o == lfps_duty(level_o))
    else $error("duty does not match level");

  // A restarted program always begins at its first segment.
  a_restart_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && restarted_o |-> segment_o == '0)
    else $error("restart outside segment zero");

  // Level and segment stay inside the program tables.
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_o <= LEVEL_MAX && segment_o < SEG_W'(MAX_SEGS))
    else $error("level or segment out of range");

endmodule

bind led_fade_program_sequencer lfps_checker u_lfps_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for the LED fade program sequencer.
`timescale 1ns / 1ps

module testbench;
  import lfps_pkg::*;

  // Quiet cycles (no word moving on either channel, no register write) before the run is declared hung.
  localparam int HANG_LIMIT = 2000;
  // Mismatches printed before further ones are only counted.
  localparam int PRINT_CAP = 100;

  // Our own copy of the brightness curve, in hundredths of a percent.
  localparam logic [DUTY_W-1:0] BRIGHTNESS [TABLE_STEPS] = '{
    14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd1, 14'd1,
    14'd1, 14'd1, 14'd2, 14'd2, 14'd2, 14'd2, 14'd3, 14'd3, 14'd4, 14'd4,
    14'd5, 14'd5, 14'd6, 14'd7, 14'd8, 14'd9, 14'd9, 14'd11, 14'd12, 14'd13,
    14'd14, 14'd16, 14'd18, 14'd19, 14'd21, 14'd24, 14'd26, 14'd29, 14'd32,
    14'd35, 14'd38, 14'd42, 14'd46, 14'd51, 14'd56, 14'd62, 14'd68, 14'd74,
    14'd82, 14'd90, 14'd99, 14'd108, 14'd119, 14'd130, 14'd143, 14'd157,
    14'd172, 14'd189, 14'd207, 14'd228, 14'd250, 14'd274, 14'd300, 14'd330,
    14'd362, 14'd397, 14'd435, 14'd477, 14'd523, 14'd574, 14'd629, 14'd690,
    14'd757, 14'd830, 14'd911, 14'd999, 14'd1095, 14'd1201, 14'd1317,
    14'd1444, 14'd1583, 14'd1736, 14'd1904, 14'd2088, 14'd2289, 14'd2510,
    14'd2753, 14'd3018, 14'd3310, 14'd3629, 14'd3980, 14'd4364, 14'd4785,
    14'd5247, 14'd5753, 14'd6308, 14'd6917, 14'd7584, 14'd8316, 14'd9119,
    14'd10000
  };

  // Program shapes: how many segments, where each segment starts and ends, and
  // which tick register paces it.
  localparam logic [SEG_W-1:0] STAGE_COUNT [NUM_PROGS] = '{3'd1, 3'd2, 3'd2, 3'd6};
  localparam logic [LEVEL_W-1:0] STAGE_START [NUM_PROGS][MAX_SEGS] = '{
    '{7'd100, 7'd0,   7'd0,   7'd0,  7'd0,   7'd0},
    '{7'd0,   7'd100, 7'd0,   7'd0,  7'd0,   7'd0},
    '{7'd0,   7'd100, 7'd0,   7'd0,  7'd0,   7'd0},
    '{7'd20,  7'd100, 7'd100, 7'd50, 7'd100, 7'd100}
  };
  localparam logic [LEVEL_W-1:0] STAGE_END [NUM_PROGS][MAX_SEGS] = '{
    '{7'd100, 7'd0,   7'd0,  7'd0,   7'd0,   7'd0},
    '{7'd100, 7'd0,   7'd0,  7'd0,   7'd0,   7'd0},
    '{7'd100, 7'd0,   7'd0,  7'd0,   7'd0,   7'd0},
    '{7'd100, 7'd100, 7'd50, 7'd100, 7'd100, 7'd20}
  };
  localparam seg_kind_e STAGE_TIMER [NUM_PROGS][MAX_SEGS] = '{
    '{KIND_STEADY, KIND_HOLD,   KIND_HOLD,  KIND_HOLD,  KIND_HOLD, KIND_HOLD},
    '{KIND_SLOW,   KIND_SLOW,   KIND_HOLD,  KIND_HOLD,  KIND_HOLD, KIND_HOLD},
    '{KIND_NORMAL, KIND_NORMAL, KIND_HOLD,  KIND_HOLD,  KIND_HOLD, KIND_HOLD},
    '{KIND_NORMAL, KIND_HOLD,   KIND_QUICK, KIND_QUICK, KIND_HOLD, KIND_NORMAL}
  };

  // The tick registers in the order of their indexes.
  localparam logic [CFG_IDX_W-1:0] TICK_REGS [5] =
    '{REG_SLOW, REG_NORMAL, REG_QUICK, REG_HOLD, REG_STEADY};

  // Flavors of register settings used by the random phases.
  typedef enum int {
    SET_ONES,
    SET_TINY,
    SET_LONGEST,
    SET_SHORT,
    SET_ANY
  } tick_setting_e;

  // Every input of the block starts at a known value.
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [PROG_W-1:0]    program_req_i = PROG_STEADY;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [DUTY_W-1:0]    duty_o;
  logic [LEVEL_W-1:0]   level_o;
  logic [SEG_W-1:0]     segment_o;
  logic                 restarted_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_SLOW;
  logic [TICK_W-1:0]    cfg_wdata_i = '0;

  led_fade_program_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .program_req_i (program_req_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .duty_o        (duty_o),
    .level_o       (level_o),
    .segment_o     (segment_o),
    .restarted_o   (restarted_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Expected results, oldest first, and the run's bookkeeping.
  result_t duty_expected [$];
  int fails = 0;
  int ticks_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int program_changes = 0;
  int deepest_blink_seg = 0;

  // Idle mix, in percent of cycles, and the long receiver hold-off request.
  int gap_pct = 0;
  int stall_pct = 0;
  int holdoff_req = 0;
  int holdoff_left = 0;
  int quiet_cycles = 0;

  // Predictor state: the program, segment, level and dwell counter that the
  // block should hold, plus its copy of the tick registers.
  logic [PROG_W-1:0]  cur_prog;
  logic [SEG_W-1:0]   cur_seg;
  logic [LEVEL_W-1:0] cur_level;
  logic [TICK_W-1:0]  dwell;
  logic [TICK_W-1:0]  tick_reg [5];

  function automatic void reset_fade_model();
    cur_prog = PROG_STEADY;
    cur_seg = '0;
    cur_level = LEVEL_RESET;
    dwell = '0;
    tick_reg = '{16'd20, 16'd10, 16'd2, 16'd200, 16'd10};
  endfunction

  // A register holding zero still paces its segment at one tick per level.
  function automatic logic [TICK_W-1:0] dwell_of(input logic [PROG_W-1:0] p,
                                                 input logic [SEG_W-1:0] s);
    logic [TICK_W-1:0] v;
    v = tick_reg[STAGE_TIMER[p][s]];
    return (v == '0) ? TICK_W'(1) : v;
  endfunction

  function automatic void enter_stage();
    cur_level = STAGE_START[cur_prog][cur_seg];
    dwell = dwell_of(cur_prog, cur_seg);
  endfunction

  // One millisecond tick: what the block should show for it, and its next state.
  function automatic result_t fade_tick(input logic [PROG_W-1:0] req);
    result_t r;
    logic [LEVEL_W-1:0] shown;
    logic [LEVEL_W-1:0] goal;
    logic [DUTY_W-1:0]  d;
    r.restarted = 1'b0;
    // A new request aborts whatever is running; an expired dwell with no
    // segment advance (only right after reset) restarts from segment zero
    // without flagging a restart.
    if (req != cur_prog) begin
      cur_prog = req;
      cur_seg = '0;
      enter_stage();
      r.restarted = 1'b1;
    end else if (dwell == '0) begin
      cur_seg = '0;
      enter_stage();
    end
    shown = (cur_level > LEVEL_W'(TABLE_STEPS - 1)) ? LEVEL_W'(TABLE_STEPS - 1) : cur_level;
    d = BRIGHTNESS[shown];
    r.duty = (d > DUTY_W'(DUTY_FULL)) ? DUTY_W'(DUTY_FULL) : d;
    r.level = cur_level;
    r.segment = cur_seg;
    if (r.restarted) program_changes++;
    if (cur_prog == PROG_BLINK && int'(cur_seg) > deepest_blink_seg)
      deepest_blink_seg = int'(cur_seg);

    dwell = dwell - TICK_W'(1);
    if (dwell == '0) begin
      goal = STAGE_END[cur_prog][cur_seg];
      if (cur_level != goal) begin
        cur_level = (cur_level < goal) ? cur_level + LEVEL_W'(1) : cur_level - LEVEL_W'(1);
        dwell = dwell_of(cur_prog, cur_seg);
      end else begin
        // Past the last segment the program loops back quietly.
        cur_seg = (cur_seg + SEG_W'(1) >= STAGE_COUNT[cur_prog]) ? '0 : cur_seg + SEG_W'(1);
        enter_stage();
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    fails++;
    if (fails <= PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Offers one tick word, with a random gap before it when the sender idles,
  // and returns at the falling edge after the word was taken. Valid stays high
  // from one word to the next unless a gap falls between them.
  task automatic send_tick(input logic [PROG_W-1:0] req);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    program_req_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    duty_expected.push_back(fade_tick(req));
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Stops offering and waits until every expected result has come out. The
  // block produces one result per word, so an empty queue means it is idle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (duty_expected.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Drives one register write for the coming edge. The caller lowers the
  // write enable once its series of writes is done.
  task automatic write_tick_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [TICK_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    if (idx <= REG_STEADY) tick_reg[idx] = value;
    reg_writes++;
  endtask

  task automatic load_tick_regs(input tick_setting_e flavor);
    logic [TICK_W-1:0] v;
    foreach (TICK_REGS[i]) begin
      case (flavor)
        SET_ONES:    v = TICK_W'(1);
        SET_TINY:    v = TICK_W'($urandom_range(0, 3));
        SET_LONGEST: v = '1;
        SET_SHORT:   v = TICK_W'($urandom_range(1, 12));
        default:     v = TICK_W'($urandom);
      endcase
      write_tick_reg(TICK_REGS[i], v);
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Runs of one program long enough to walk through its segments, mixed with
  // short bursts of random requests that break sequences mid-segment.
  task automatic send_program_runs(input int count);
    int sent;
    int run;
    logic [PROG_W-1:0] prog;
    sent = 0;
    while (sent < count) begin
      prog = PROG_W'($urandom);
      if ($urandom_range(0, 99) < 85) run = $urandom_range(1, 400);
      else run = $urandom_range(1, 3);
      for (int k = 0; k < run && sent < count; k++) begin
        if (run <= 3) prog = PROG_W'($urandom);
        send_tick(prog);
        sent++;
      end
    end
  endtask

  task automatic set_idle_mix(input int mix);
    case (mix % 4)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 49; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 49; end
      default: begin gap_pct = 21; stall_pct = 21; end
    endcase
  endtask

  // First ticks run under the reset register values: steady-on at first
  // (the program it starts in, so no restart), then a change to each program
  // and back, each change aborting the running one.
  task automatic test_program_changes();
    logic [PROG_W-1:0] seq [11];
    seq = '{PROG_STEADY, PROG_STEADY, PROG_STEADY, PROG_SLOW, PROG_SLOW, PROG_SLOW,
            PROG_NORMAL, PROG_NORMAL, PROG_BLINK, PROG_BLINK, PROG_STEADY};
    foreach (seq[i]) send_tick(seq[i]);
    drain_results();
  endtask

  // Registers written as zero must pace at one tick; writes to indexes past
  // the last register must leave every register alone.
  task automatic test_tick_register_edges();
    foreach (TICK_REGS[i]) write_tick_reg(TICK_REGS[i], '0);
    for (int i = int'(REG_STEADY) + 1; i < 2 ** CFG_IDX_W; i++)
      write_tick_reg(CFG_IDX_W'(i), TICK_W'($urandom));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    repeat (8) send_tick(PROG_BLINK);
    repeat (3) send_tick(PROG_SLOW);
    drain_results();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering,
  // so the block fills up and stalls its input; then the sender waits for all.
  task automatic test_backpressure();
    load_tick_regs(SET_SHORT);
    set_idle_mix(0);
    holdoff_req = 60;
    send_program_runs(90);
    drain_results();
  endtask

  task automatic test_random_programs();
    tick_setting_e plan [6];
    plan = '{SET_ONES, SET_TINY, SET_LONGEST, SET_TINY, SET_ANY, SET_ONES};
    foreach (plan[i]) begin
      load_tick_regs(plan[i]);
      set_idle_mix(i);
      send_program_runs(240);
      drain_results();
    end
    set_idle_mix(0);
  endtask

  // Receiver: random stalls at the current mix, or a counted long hold-off.
  always @(negedge clk_i) begin
    if (holdoff_req > 0) begin
      holdoff_left = holdoff_req;
      holdoff_req = 0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Result checker: every word taken on the output is matched against the
  // oldest expectation, field by field.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (duty_expected.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected: duty %0d level %0d",
                                duty_o, level_o));
      end else begin
        want = duty_expected.pop_front();
        results_checked++;
        if (duty_o !== want.duty)
          flag_mismatch($sformatf("duty %0d, expected %0d", duty_o, want.duty));
        if (level_o !== want.level)
          flag_mismatch($sformatf("level %0d, expected %0d", level_o, want.level));
        if (segment_o !== want.segment)
          flag_mismatch($sformatf("segment %0d, expected %0d", segment_o, want.segment));
        if (restarted_o !== want.restarted)
          flag_mismatch($sformatf("restarted %0b, expected %0b", restarted_o,
                                  want.restarted));
      end
    end
  end

  // Watchdog: ends the run when no word moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
               HANG_LIMIT, duty_expected.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    reset_fade_model();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_program_changes();
    test_tick_register_edges();
    test_backpressure();
    test_random_programs();

    drain_results();
    if (duty_expected.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", duty_expected.size()));
    $display("Covered %0d ticks, %0d results checked, %0d register writes, %0d restarts.",
             ticks_sent, results_checked, reg_writes, program_changes);
    $display("Blink reached segment %0d; idle mixes none, sender, receiver and both.",
             deepest_blink_seg);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lfps_pkg.sv
design/lfps_cfg_regs.sv
design/lfps_core.sv
design/led_fade_program_sequencer.sv
design/lfps_checker.sv
verif/testbench.sv
